// ===== rtl/rmj_pkg.sv =====
// Shared types and constants for the radar measurement Jacobian core.
package rmj_pkg;

    localparam int ADDR_W     = 3;
    localparam int ROOT_STEPS = 64;
    localparam int DIV_STEPS  = 32;
    localparam int LANES      = 6;

    localparam logic [ADDR_W-3:0] REG_MIN_RANGE_SQ   = 1'b0;
    localparam logic [31:0]       MIN_RANGE_SQ_RESET = 32'd4295;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // Front end result: magnitudes, signs, collision and overflow flags, range squared and
    // the (|a * cross| * 2^F) dividends split into high and low 64-bit words.
    typedef struct packed {
        logic        coll;
        logic        sx;
        logic        sy;
        logic        cneg;
        logic [31:0] apx;
        logic [31:0] apy;
        logic [63:0] rho2;
        logic [63:0] nh0;
        logic [63:0] nl0;
        logic [63:0] nh1;
        logic [63:0] nl1;
        logic        ov0;
        logic        ov1;
    } t_front;

    // Side data that travels with the final divide row.
    typedef struct packed {
        logic        coll;
        logic        sx;
        logic        sy;
        logic        cneg;
        logic [63:0] root;
        logic [63:0] rho2;
        logic [31:0] lb0;
        logic [31:0] lb1;
        logic [5:0]  ovf;
    } t_p2;

endpackage

// ===== rtl/rmj_front.sv =====
// Front end: squares, cross product, and the first wide dividends.
module rmj_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic signed [31:0]   i_vel_x,
    input  logic signed [31:0]   i_vel_y,
    input  logic [31:0]          i_thr,
    output logic                 o_vld,
    output rmj_pkg::t_front      o_fr
);
    import rmj_pkg::*;

    localparam int NW = 96 + FRAC_BITS;

    logic [4:0] r_vld;

    // stage 0
    logic               r_sx, r_sy;
    logic [31:0]        r_apx0, r_apy0;
    logic [63:0]        r_sqx, r_sqy;
    logic signed [63:0] r_p1, r_p2;
    logic signed [63:0] w_sqx, w_sqy, w_p1, w_p2;

    // stage 1
    logic        r_coll1, r_sx1, r_sy1, r_cneg1;
    logic [31:0] r_apx1, r_apy1;
    logic [63:0] r_rho2_1, r_cmag;
    logic [63:0] w_rho2;

    // stage 2
    logic        r_coll2, r_sx2, r_sy2, r_cneg2;
    logic [31:0] r_apx2, r_apy2;
    logic [63:0] r_rho2_2;
    logic [63:0] r_pp0lo, r_pp0hi, r_pp1lo, r_pp1hi;

    // stage 3
    logic        r_coll3, r_sx3, r_sy3, r_cneg3;
    logic [31:0] r_apx3, r_apy3;
    logic [63:0] r_rho2_3;
    logic [95:0] r_m0, r_m1;

    logic [NW-1:0] w_n0, w_n1;
    logic [63:0]   w_nh0, w_nh1;

    assign w_sqx = i_pos_x * i_pos_x;
    assign w_sqy = i_pos_y * i_pos_y;
    assign w_p1  = i_vel_x * i_pos_y;
    assign w_p2  = i_vel_y * i_pos_x;
    assign w_rho2 = r_sqx + r_sqy;

    assign w_n0  = {r_m0, {FRAC_BITS{1'b0}}};
    assign w_n1  = {r_m1, {FRAC_BITS{1'b0}}};
    assign w_nh0 = 64'(w_n0 >> 64);
    assign w_nh1 = 64'(w_n1 >> 64);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx   <= i_pos_x[31];
            r_sy   <= i_pos_y[31];
            r_apx0 <= i_pos_x[31] ? (~i_pos_x + 32'd1) : i_pos_x;
            r_apy0 <= i_pos_y[31] ? (~i_pos_y + 32'd1) : i_pos_y;
            r_sqx  <= w_sqx;
            r_sqy  <= w_sqy;
            r_p1   <= w_p1;
            r_p2   <= w_p2;

            r_coll1  <= (w_rho2 <= {32'd0, i_thr});
            r_sx1    <= r_sx;
            r_sy1    <= r_sy;
            r_cneg1  <= (r_p1 < r_p2);
            r_cmag   <= (r_p1 < r_p2) ? 64'(r_p2 - r_p1) : 64'(r_p1 - r_p2);
            r_apx1   <= r_apx0;
            r_apy1   <= r_apy0;
            r_rho2_1 <= w_rho2;

            r_coll2  <= r_coll1;
            r_sx2    <= r_sx1;
            r_sy2    <= r_sy1;
            r_cneg2  <= r_cneg1;
            r_apx2   <= r_apx1;
            r_apy2   <= r_apy1;
            r_rho2_2 <= r_rho2_1;
            r_pp0lo  <= r_apy1 * r_cmag[31:0];
            r_pp0hi  <= r_apy1 * r_cmag[63:32];
            r_pp1lo  <= r_apx1 * r_cmag[31:0];
            r_pp1hi  <= r_apx1 * r_cmag[63:32];

            r_coll3  <= r_coll2;
            r_sx3    <= r_sx2;
            r_sy3    <= r_sy2;
            r_cneg3  <= r_cneg2;
            r_apx3   <= r_apx2;
            r_apy3   <= r_apy2;
            r_rho2_3 <= r_rho2_2;
            r_m0     <= {32'd0, r_pp0lo} + {r_pp0hi, 32'd0};
            r_m1     <= {32'd0, r_pp1lo} + {r_pp1hi, 32'd0};

            o_fr.coll <= r_coll3;
            o_fr.sx   <= r_sx3;
            o_fr.sy   <= r_sy3;
            o_fr.cneg <= r_cneg3;
            o_fr.apx  <= r_apx3;
            o_fr.apy  <= r_apy3;
            o_fr.rho2 <= r_rho2_3;
            o_fr.nh0  <= w_nh0;
            o_fr.nl0  <= w_n0[63:0];
            o_fr.nh1  <= w_nh1;
            o_fr.nl1  <= w_n1[63:0];
            o_fr.ov0  <= (w_nh0 >= r_rho2_3);
            o_fr.ov1  <= (w_nh1 >= r_rho2_3);
        end
    end

    assign o_vld = r_vld[4];

endmodule

// ===== rtl/rmj_root_cell.sv =====
// One cell of the square root row: retire one root bit per cycle while enabled.
module rmj_root_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [65:0] i_rem,
    input  logic [63:0] i_root,
    input  logic [1:0]  i_pair,
    output logic [65:0] o_rem,
    output logic [63:0] o_root
);
    import rmj_pkg::*;

    logic [67:0] w_acc, w_trial, w_diff;
    logic        w_ge;

    assign w_acc   = {i_rem, i_pair};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_acc >= w_trial);
    assign w_diff  = w_acc - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_ge ? w_diff[65:0] : w_acc[65:0];
            o_root <= {i_root[62:0], w_ge};
        end
    end

endmodule

// ===== rtl/rmj_div_cell.sv =====
// One cell of a restoring divide row: retire one quotient bit per cycle while enabled.
module rmj_div_cell #(
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [63:0]   i_div,
    input  logic [63:0]   i_rem,
    input  logic          i_bit,
    input  logic [QW-1:0] i_quo,
    output logic [63:0]   o_rem,
    output logic [QW-1:0] o_quo
);
    import rmj_pkg::*;

    logic [64:0] w_acc, w_diff;
    logic        w_ge;

    assign w_acc  = {i_rem, i_bit};
    assign w_ge   = (w_acc >= {1'b0, i_div});
    assign w_diff = w_acc - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_diff[63:0] : w_acc[63:0];
            o_quo <= {i_quo[QW-2:0], w_ge};
        end
    end

endmodule

// ===== rtl/radar_measurement_jacobian_core.sv =====
// Top level of the radar polar measurement Jacobian core.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------------
//  request   in         i_in_valid / o_in_ready   i_pos_x, i_pos_y, i_vel_x, i_vel_y
//  result    out        o_out_valid / i_out_ready o_drange_*, o_dbearing_*,
//                                                 o_drate_*, o_valid_res
//  config    in         APB psel/penable/pready   min_range_squared at byte 0
//
// One request enters per cycle while the row advances; each request yields one
// result through 5 front stages, 64 square root cells, 1 bridge stage, 32 divide
// cells and the output register. The 64-cell root row is the longest part.
// Reset is synchronous and active low; it clears every valid bit and loads
// the threshold with its reset value. The whole row holds only when its last
// cell carries a result and the output register still holds an untaken one.
module radar_measurement_jacobian_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  logic signed [31:0]            i_vel_x,
    input  logic signed [31:0]            i_vel_y,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_drange_dpx,
    output logic signed [31:0]            o_drange_dpy,
    output logic signed [31:0]            o_dbearing_dpx,
    output logic signed [31:0]            o_dbearing_dpy,
    output logic signed [31:0]            o_drate_dpx,
    output logic signed [31:0]            o_drate_dpy,
    output logic                          o_valid_res,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmj_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rmj_pkg::*;

    localparam int NBW = 32 + 2 * FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [31:0] r_thr;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_MIN_RANGE_SQ) ? r_thr : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= MIN_RANGE_SQ_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[ADDR_W-1:2] == REG_MIN_RANGE_SQ) begin
            r_thr <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: advance every stage together unless the last cell
    // holds a result that the output register cannot take.
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_last_vld;

    assign w_adv      = !w_last_vld || !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ------------------------------------------------------------------
    // Front end
    // ------------------------------------------------------------------
    logic   w_fr_vld;
    t_front w_fr;

    rmj_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (i_in_valid),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_vel_x (i_vel_x),
        .i_vel_y (i_vel_y),
        .i_thr   (r_thr),
        .o_vld   (w_fr_vld),
        .o_fr    (w_fr)
    );

    // ------------------------------------------------------------------
    // Root row: square root of rho2 * 2^64, plus the two 64-bit quotients
    // (|a * cross| * 2^F) / rho2 that feed the range-rate entries.
    // ------------------------------------------------------------------
    t_front      r_s1     [ROOT_STEPS];
    logic        r_v1     [ROOT_STEPS];
    logic [65:0] w_rt_rem [ROOT_STEPS];
    logic [63:0] w_rt_root[ROOT_STEPS];
    logic [63:0] w_q_rem  [ROOT_STEPS][2];
    logic [63:0] w_q_quo  [ROOT_STEPS][2];

    for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_root
        t_front      w_in;
        logic        w_vin;
        logic [65:0] w_rem_in;
        logic [63:0] w_root_in;
        logic [63:0] w_qr_in [2];
        logic [63:0] w_qq_in [2];
        logic [1:0]  w_pair;

        if (s == 0) begin : g_first
            assign w_in       = w_fr;
            assign w_vin      = w_fr_vld;
            assign w_rem_in   = '0;
            assign w_root_in  = '0;
            assign w_qr_in[0] = w_fr.ov0 ? 64'd0 : w_fr.nh0;
            assign w_qr_in[1] = w_fr.ov1 ? 64'd0 : w_fr.nh1;
            assign w_qq_in[0] = '0;
            assign w_qq_in[1] = '0;
        end else begin : g_next
            assign w_in       = r_s1[s-1];
            assign w_vin      = r_v1[s-1];
            assign w_rem_in   = w_rt_rem[s-1];
            assign w_root_in  = w_rt_root[s-1];
            assign w_qr_in[0] = w_q_rem[s-1][0];
            assign w_qr_in[1] = w_q_rem[s-1][1];
            assign w_qq_in[0] = w_q_quo[s-1][0];
            assign w_qq_in[1] = w_q_quo[s-1][1];
        end

        // The radicand's low 64 bits are zero: feed rho2, then zeros.
        if (s < ROOT_STEPS / 2) begin : g_pair_hi
            assign w_pair = w_in.rho2[63-2*s -: 2];
        end else begin : g_pair_lo
            assign w_pair = 2'b00;
        end

        rmj_root_cell u_root (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rem  (w_rem_in),
            .i_root (w_root_in),
            .i_pair (w_pair),
            .o_rem  (w_rt_rem[s]),
            .o_root (w_rt_root[s])
        );

        rmj_div_cell #(
            .QW (64)
        ) u_q0 (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_div (w_in.rho2),
            .i_rem (w_qr_in[0]),
            .i_bit (w_in.nl0[63-s]),
            .i_quo (w_qq_in[0]),
            .o_rem (w_q_rem[s][0]),
            .o_quo (w_q_quo[s][0])
        );

        rmj_div_cell #(
            .QW (64)
        ) u_q1 (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_div (w_in.rho2),
            .i_rem (w_qr_in[1]),
            .i_bit (w_in.nl1[63-s]),
            .i_quo (w_qq_in[1]),
            .o_rem (w_q_rem[s][1]),
            .o_quo (w_q_quo[s][1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1[s] <= 1'b0;
            end else if (w_adv) begin
                r_v1[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s1[s] <= w_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Bridge stage: form the six 32-bit divides and their overflow flags.
    // Lanes: 0 px/rho, 1 py/rho, 2 py/rho2, 3 px/rho2,
    //        4 py*cross/rho^3, 5 px*cross/rho^3.
    // ------------------------------------------------------------------
    t_front         w_e;
    logic [63:0]    w_r;
    logic [63:0]    w_q0, w_q1;
    logic [63:0]    w_hr0, w_hr1;
    logic [NBW-1:0] w_nb0, w_nb1;
    logic [63:0]    w_hb0, w_hb1;

    logic        r_br_vld;
    t_p2         r_br;
    logic [63:0] r_br_h [LANES];

    assign w_e   = r_s1[ROOT_STEPS-1];
    assign w_r   = w_rt_root[ROOT_STEPS-1];
    assign w_q0  = w_q_quo[ROOT_STEPS-1][0];
    assign w_q1  = w_q_quo[ROOT_STEPS-1][1];
    assign w_hr0 = 64'(w_e.apx) << FRAC_BITS;
    assign w_hr1 = 64'(w_e.apy) << FRAC_BITS;
    assign w_nb0 = {w_e.apy, {(2*FRAC_BITS){1'b0}}};
    assign w_nb1 = {w_e.apx, {(2*FRAC_BITS){1'b0}}};
    assign w_hb0 = 64'(w_nb0 >> 32);
    assign w_hb1 = 64'(w_nb1 >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_br_vld <= 1'b0;
        end else if (w_adv) begin
            r_br_vld <= r_v1[ROOT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_br.coll   <= w_e.coll;
            r_br.sx     <= w_e.sx;
            r_br.sy     <= w_e.sy;
            r_br.cneg   <= w_e.cneg;
            r_br.root   <= w_r;
            r_br.rho2   <= w_e.rho2;
            r_br.lb0    <= w_nb0[31:0];
            r_br.lb1    <= w_nb1[31:0];
            r_br.ovf[0] <= (w_hr0 >= w_r);
            r_br.ovf[1] <= (w_hr1 >= w_r);
            r_br.ovf[2] <= (w_hb0 >= w_e.rho2);
            r_br.ovf[3] <= (w_hb1 >= w_e.rho2);
            // saturate the rate entries when the first quotient overflowed,
            // reached 2^63, or would give a second quotient of 2^32 or more
            r_br.ovf[4] <= w_e.ov0 || w_q0[63] || (w_q0 >= w_r);
            r_br.ovf[5] <= w_e.ov1 || w_q1[63] || (w_q1 >= w_r);
            r_br_h[0]   <= w_hr0;
            r_br_h[1]   <= w_hr1;
            r_br_h[2]   <= w_hb0;
            r_br_h[3]   <= w_hb1;
            r_br_h[4]   <= w_q0;
            r_br_h[5]   <= w_q1;
        end
    end

    // ------------------------------------------------------------------
    // Divide row: six 32-bit restoring divides side by side.
    // ------------------------------------------------------------------
    t_p2         r_s2     [DIV_STEPS];
    logic        r_v2     [DIV_STEPS];
    logic [63:0] w_d_rem  [DIV_STEPS][LANES];
    logic [31:0] w_d_quo  [DIV_STEPS][LANES];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        t_p2         w_in;
        logic        w_vin;
        logic [63:0] w_rem_in [LANES];
        logic [31:0] w_quo_in [LANES];

        if (s == 0) begin : g_first
            assign w_in  = r_br;
            assign w_vin = r_br_vld;
            for (genvar k = 0; k < LANES; k++) begin : g_init
                assign w_rem_in[k] = r_br_h[k];
                assign w_quo_in[k] = '0;
            end
        end else begin : g_next
            assign w_in  = r_s2[s-1];
            assign w_vin = r_v2[s-1];
            for (genvar k = 0; k < LANES; k++) begin : g_link
                assign w_rem_in[k] = w_d_rem[s-1][k];
                assign w_quo_in[k] = w_d_quo[s-1][k];
            end
        end

        for (genvar k = 0; k < LANES; k++) begin : g_lane
            logic [63:0] w_div;
            logic        w_bit;

            if (k == 2) begin : g_b0
                assign w_div = w_in.rho2;
                assign w_bit = w_in.lb0[31-s];
            end else if (k == 3) begin : g_b1
                assign w_div = w_in.rho2;
                assign w_bit = w_in.lb1[31-s];
            end else begin : g_r
                assign w_div = w_in.root;
                assign w_bit = 1'b0;
            end

            rmj_div_cell #(
                .QW (32)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_div (w_div),
                .i_rem (w_rem_in[k]),
                .i_bit (w_bit),
                .i_quo (w_quo_in[k]),
                .o_rem (w_d_rem[s][k]),
                .o_quo (w_d_quo[s][k])
            );
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v2[s] <= 1'b0;
            end else if (w_adv) begin
                r_v2[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s2[s] <= w_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: apply signs, saturate, zero on collision.
    // ------------------------------------------------------------------
    function automatic logic [31:0] sat_q(input logic ovf, input logic [31:0] q,
                                          input logic neg);
        if (neg) begin
            sat_q = (ovf || q > SAT_NEG) ? SAT_NEG : (~q + 32'd1);
        end else begin
            sat_q = (ovf || q[31]) ? SAT_POS : q;
        end
    endfunction

    t_p2         w_z;
    logic [5:0]  w_neg;
    logic [31:0] w_res [LANES];

    assign w_last_vld = r_v2[DIV_STEPS-1];
    assign w_z        = r_s2[DIV_STEPS-1];
    assign w_neg[0]   = w_z.sx;
    assign w_neg[1]   = w_z.sy;
    assign w_neg[2]   = !w_z.sy;
    assign w_neg[3]   = w_z.sx;
    assign w_neg[4]   = w_z.sy ^ w_z.cneg;
    assign w_neg[5]   = !(w_z.sx ^ w_z.cneg);

    for (genvar k = 0; k < LANES; k++) begin : g_sat
        assign w_res[k] = w_z.coll ? 32'd0
                        : sat_q(w_z.ovf[k], w_d_quo[DIV_STEPS-1][k], w_neg[k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv && w_last_vld) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last_vld) begin
            o_drange_dpx   <= w_res[0];
            o_drange_dpy   <= w_res[1];
            o_dbearing_dpx <= w_res[2];
            o_dbearing_dpy <= w_res[3];
            o_drate_dpx    <= w_res[4];
            o_drate_dpy    <= w_res[5];
            o_valid_res    <= !w_z.coll;
        end
    end

endmodule

// ===== tb/radar_measurement_jacobian_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the radar measurement Jacobian core.

module radar_measurement_jacobian_core_tb;
    import rmj_pkg::*;

    localparam int FRAC = 16;
    localparam int RUN_LENGTH_NS = 3_000_000;

    typedef struct {
        logic [31:0] ent[6];
        logic        ok;
    } t_jacobian;

    // Predict Jacobian entries and match them in order against the core's output.
    class t_jacobian_scoreboard;
        logic [31:0] min_range_sq;
        t_jacobian   expected_q[$];
        int          errors;

        function new();
            min_range_sq = MIN_RANGE_SQ_RESET;
            errors = 0;
        endfunction

        // Clip a magnitude with a sign to signed Q16.16.
        function logic [31:0] clip(logic [127:0] mag, bit neg);
            if (neg) begin
                if (mag > 128'h8000_0000) return SAT_NEG;
                return 32'(-mag[31:0]);
            end
            if (mag > 128'h7FFF_FFFF) return SAT_POS;
            return mag[31:0];
        endfunction

        function void note_request(logic signed [31:0] px, logic signed [31:0] py,
                                   logic signed [31:0] vx, logic signed [31:0] vy);
            t_jacobian       r;
            logic [63:0]     apx, apy, rho2, root, cmag, a;
            logic [63:0]     c;
            logic [127:0]    q, target;
            logic signed [63:0] p1, p2;
            bit              cneg, neg;
            apx = px < 0 ? 64'(-64'(px)) : 64'(px);
            apy = py < 0 ? 64'(-64'(py)) : 64'(py);
            rho2 = apx * apx + apy * apy;
            for (int j = 0; j < 6; j++) r.ent[j] = '0;
            r.ok = 1'b0;
            if (rho2 > 64'(min_range_sq)) begin
                // floor(sqrt(rho2 * 2^64)), bit by bit
                target = {rho2, 64'd0};
                root = '0;
                for (int b = 63; b >= 0; b--) begin
                    c = root | (64'd1 << b);
                    if ((128'(c) * 128'(c)) <= target) root = c;
                end
                r.ent[0] = clip((128'(apx) << (FRAC + 32)) / 128'(root), px < 0);
                r.ent[1] = clip((128'(apy) << (FRAC + 32)) / 128'(root), py < 0);
                r.ent[2] = clip((128'(apy) << (2 * FRAC)) / 128'(rho2), !(py < 0));
                r.ent[3] = clip((128'(apx) << (2 * FRAC)) / 128'(rho2), px < 0);
                p1 = 64'(vx) * 64'(py);
                p2 = 64'(vy) * 64'(px);
                cneg = p1 < p2;
                cmag = cneg ? 64'(p2 - p1) : 64'(p1 - p2);
                for (int j = 0; j < 2; j++) begin
                    a = j == 0 ? apy : apx;
                    neg = j == 0 ? ((py < 0) != cneg) : !((px < 0) != cneg);
                    q = ((128'(a) * 128'(cmag)) << FRAC) / 128'(rho2);
                    if (q[127:63] != '0) q = 128'd1 << 64;
                    else q = (q << 32) / 128'(root);
                    r.ent[4 + j] = clip(q, neg);
                end
                r.ok = 1'b1;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_jacobian act);
            t_jacobian e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, nothing pending", $time);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            for (int j = 0; j < 6; j++)
                if (act.ent[j] !== e.ent[j]) begin
                    $display("%0t: entry %0d expected %h actual %h",
                             $time, j, e.ent[j], act.ent[j]);
                    errors++;
                end
            if (act.ok !== e.ok) begin
                $display("%0t: valid_res expected %b actual %b", $time, e.ok, act.ok);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    logic signed [31:0] i_pos_x, i_pos_y, i_vel_x, i_vel_y;
    logic o_out_valid, i_out_ready;
    logic signed [31:0] o_drange_dpx, o_drange_dpy, o_dbearing_dpx, o_dbearing_dpy;
    logic signed [31:0] o_drate_dpx, o_drate_dpy;
    logic o_valid_res;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    radar_measurement_jacobian_core #(.FRAC_BITS(FRAC)) dut (.*);

    t_jacobian_scoreboard sb = new();

    // Idle knobs, percent of cycles; long_hold counts down a forced result stall.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int long_hold      = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Result side: stall at random or for a forced stretch.
    always @(posedge i_clk) begin
        if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Note accepted requests and check accepted results at the same edge.
    always @(posedge i_clk) begin
        t_jacobian act;
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_request(i_pos_x, i_pos_y, i_vel_x, i_vel_y);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            act.ent[0] = o_drange_dpx;
            act.ent[1] = o_drange_dpy;
            act.ent[2] = o_dbearing_dpx;
            act.ent[3] = o_dbearing_dpy;
            act.ent[4] = o_drate_dpx;
            act.ent[5] = o_drate_dpy;
            act.ok     = o_valid_res;
            sb.check_result(act);
        end
    end

    // Write the threshold over the APB port; call only while the core is idle.
    task automatic write_min_range(logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_MIN_RANGE_SQ, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.min_range_sq = value;
        @(posedge i_clk);
    endtask

    // Offer one request and hold it until the core takes it; then idle a
    // random number of cycles, each with the idle percentage.
    task automatic send_request(logic [31:0] px, logic [31:0] py,
                                logic [31:0] vx, logic [31:0] vy);
        bit taken;
        i_in_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_vel_x <= vx;
        i_vel_y <= vy;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Random field: mostly small magnitudes of random width, some full range.
    function automatic logic [31:0] rand_field();
        int w;
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(3) == 0) return v;
        w = $urandom_range(1, 31);
        v = v & ((32'd1 << w) - 1);
        if (v[w-1]) v = v | ~((32'd1 << w) - 1);
        return v;
    endfunction

    // Drain: stop offering, wait until every pending result has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] thr[8];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_vel_x = '0; i_vel_y = '0;
        i_out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: origin, threshold edges, field extremes, sign patterns.
        send_request(0, 0, 0, 0);
        send_request(65, 0, 7, 7);                  // rho2 4225, still a collision
        send_request(66, 0, 7, 7);                  // just above the reset threshold
        send_request(0, -66, 32'h7FFF_FFFF, 1);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'h8000_0000, 0, 0, 32'h8000_0000);
        send_request(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_request(100, 1, 32'h7FFF_FFFF, 32'h8000_0000);   // rate entries saturate
        send_request(32'h0001_0000, 0, 0, 32'h0001_0000);
        send_request(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000);
        send_request(300, -300, 5, 5);                        // negative cross product
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        write_min_range(32'h0);
        send_request(1, 0, 1, 1);
        send_request(0, 0, 3, 3);
        drain();
        write_min_range(32'hFFFF_FFFF);
        send_request(32'h0000_FFFF, 0, 1, 2);       // rho2 below 2^32: collision
        send_request(32'h0001_0000, 0, 1, 2);       // rho2 equals 2^32: valid
        send_request(32'h8000_0000, 32'h8000_0000, 9, 9);
        drain();

        thr[0] = MIN_RANGE_SQ_RESET;
        thr[1] = MIN_RANGE_SQ_RESET;
        thr[2] = 32'h0;
        thr[3] = 32'h0;
        thr[4] = 32'hFFFF_FFFF;
        thr[5] = $urandom;
        thr[6] = $urandom_range(1 << 20);
        thr[7] = MIN_RANGE_SQ_RESET;

        for (int ph = 0; ph < 8; ph++) begin
            write_min_range(thr[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // Fill the pipe: hold off results while requests keep coming.
            if (ph == 0) long_hold = 400;
            for (int n = 0; n < 190; n++)
                send_request(rand_field(), rand_field(), rand_field(), rand_field());
            // Pause until all results are back before the next setting.
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (120) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS radar_measurement_jacobian_core");
        else
            $display("FAIL radar_measurement_jacobian_core");
        $finish;
    end

    initial begin
        #(RUN_LENGTH_NS);
        $display("FAIL radar_measurement_jacobian_core");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rmj_pkg.sv
rtl/rmj_front.sv
rtl/rmj_root_cell.sv
rtl/rmj_div_cell.sv
rtl/radar_measurement_jacobian_core.sv
tb/radar_measurement_jacobian_core_tb.sv
